@@ rtl/tnps_pkg.sv @@
// ----------------------------------------------------------------------------
// tnps_pkg: shared definitions for the typed nearest point search core
// Table geometry, command and status codes, entry layout and scan tags.
// ----------------------------------------------------------------------------
package tnps_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

	localparam int ID_W    = 16;
	localparam int COORD_W = 24;
	localparam int CLASS_W = 2;
	localparam int CALLS_W = 16;
	localparam int OIDX_W  = 6;
	localparam int PROD_W  = 2 * COORD_W;
	localparam int DIST_W  = PROD_W + 1;
	localparam int OUTD_W  = 52;
	localparam int BEST_W  = 53;

	// (300000^2) << 16, exact
	localparam logic [BEST_W-1:0] LIMIT_SQ = 53'd5898240000000000;

	localparam logic [1:0] KIND_APPEND = 2'd0;
	localparam logic [1:0] KIND_QUERY  = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;

	localparam logic [CLASS_W-1:0] CLASS_ANY = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NO_MATCH = 2'd2;
	localparam logic [1:0] ST_BAD_CLS  = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]           id;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [CLASS_W-1:0]        cls;
		logic [CALLS_W-1:0]        calls;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [IDX_W-1:0]   idx;
		logic [ID_W-1:0]    id;
		logic [CLASS_W-1:0] cls;
		logic [CALLS_W-1:0] calls;
	} tag_t;

	typedef struct packed {
		logic              valid;
		logic              busy;
		logic [DIST_W-1:0] dist_sq;
		tag_t              tag;
	} dist_out_t;

endpackage

@@ rtl/typed_nearest_point_search_core.sv @@
// ----------------------------------------------------------------------------
// typed_nearest_point_search_core: nearest service point search
// Stores a table of service points and answers typed nearest-point queries.
// ----------------------------------------------------------------------------
//
//  channel   | handshake          | payload
//  ----------+--------------------+-----------------------------------------
//  command   | start / busy       | kind, entry_id, pos_x, pos_y,
//            |                    | service_class, entry_calls
//  result    | done (one cycle)   | status, best_id, best_calls, best_index,
//            |                    | squared_distance
//
//  Append, clear and unused commands: result in the cycle after the transfer,
//  and busy stays low, so a new command may follow in the next cycle.
//  Query: the scan reads one table entry per cycle from the single RAM read
//  port and a four-stage distance pipeline (read, delta, square, sum) drains
//  after, then the result follows; an empty table goes straight to the drain.
//  Reset clears the entry count and the sequencer; table contents are kept
//  undefined until written. The receiver cannot stall: done marks a result
//  for exactly one cycle and it must be taken then.
//
module typed_nearest_point_search_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [1:0]                           kind,
	input  logic [tnps_pkg::ID_W-1:0]            entry_id,
	input  logic signed [tnps_pkg::COORD_W-1:0]  pos_x,
	input  logic signed [tnps_pkg::COORD_W-1:0]  pos_y,
	input  logic [tnps_pkg::CLASS_W-1:0]         service_class,
	input  logic [tnps_pkg::CALLS_W-1:0]         entry_calls,
	output logic                                 done,
	output logic [1:0]                           status,
	output logic [tnps_pkg::ID_W-1:0]            best_id,
	output logic [tnps_pkg::CALLS_W-1:0]         best_calls,
	output logic [tnps_pkg::OIDX_W-1:0]          best_index,
	output logic [tnps_pkg::OUTD_W-1:0]          squared_distance
);
	import tnps_pkg::*;

	state_t                    state_q, state_nx;
	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          rd_cnt_q;
	logic                      rd_v_s1;
	logic [IDX_W-1:0]          rd_idx_s1;

	// query latched at transfer
	logic signed [COORD_W-1:0] qx_q, qy_q;
	logic [CLASS_W-1:0]        qcls_q;

	// running best
	logic                      found_q;
	logic [BEST_W-1:0]         bd_q;
	logic [ID_W-1:0]           bid_q;
	logic [CALLS_W-1:0]        bcalls_q;
	logic [IDX_W-1:0]          bidx_q;

	logic                      accept, is_append, is_query, table_full, do_write;
	logic                      issue, last_issue, pipe_busy, finish, take;
	logic [ENTRY_W-1:0]        ram_rdata;
	logic [BEST_W-1:0]         dist_ext;
	entry_t                    wr_ent;
	dist_out_t                 dres;

	assign accept     = start && !busy;
	assign is_append  = (kind == KIND_APPEND);
	assign is_query   = (kind == KIND_QUERY);
	assign table_full = (count_q >= CNT_W'(MAX_ENTRIES));
	assign do_write   = accept && is_append && (service_class != CLASS_ANY) && !table_full;
	assign last_issue = (rd_cnt_q == count_q - 1'b1);
	assign pipe_busy  = rd_v_s1 | dres.busy;
	assign wr_ent     = '{id: entry_id, x: pos_x, y: pos_y, cls: service_class,
	                      calls: entry_calls};

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && is_query) begin
					state_nx = (count_q == '0) ? S_DRAIN : S_SCAN;
				end
			end
			S_SCAN: begin
				if (last_issue) begin
					state_nx = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (!pipe_busy) begin
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		busy   = 1'b1;
		issue  = 1'b0;
		finish = 1'b0;
		case (state_q)
			S_IDLE:  busy   = 1'b0;
			S_SCAN:  issue  = 1'b1;
			S_DRAIN: finish = !pipe_busy;
			default: busy   = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			rd_cnt_q <= '0;
			rd_v_s1  <= 1'b0;
			done     <= 1'b0;
		end else begin
			state_q <= state_nx;
			rd_v_s1 <= issue;
			done    <= (accept && !is_query) || finish;
			if (do_write) begin
				count_q <= count_q + 1'b1;
			end else if (accept && (kind == KIND_CLEAR)) begin
				count_q <= '0;
			end
			// restart the read counter on every accepted command, advance while scanning
			if (accept) begin
				rd_cnt_q <= '0;
			end else if (issue) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
		end
	end

	tnps_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (do_write),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (wr_ent),
		.re    (issue),
		.raddr (rd_cnt_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_cnt_q[IDX_W-1:0];
	end

	tnps_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rd_v_s1),
		.ent      (entry_t'(ram_rdata)),
		.in_idx   (rd_idx_s1),
		.qx       (qx_q),
		.qy       (qy_q),
		.dout     (dres)
	);

	// Any-class: entry 0 always seeds the best, later ones need no farther
	// distance and strictly fewer calls. Typed: matching class, strictly nearer.
	assign dist_ext = BEST_W'(dres.dist_sq);
	always_comb begin
		if (qcls_q == CLASS_ANY) begin
			take = (dres.tag.idx == '0) ||
			       ((dist_ext <= bd_q) && (dres.tag.calls < bcalls_q));
		end else begin
			take = (dres.tag.cls == qcls_q) && (dist_ext < bd_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (accept && is_query) begin
			found_q <= 1'b0;
		end else if (dres.valid && take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_query) begin
			qx_q   <= pos_x;
			qy_q   <= pos_y;
			qcls_q <= service_class;
			bd_q   <= LIMIT_SQ;
		end else if (dres.valid && take) begin
			bd_q     <= dist_ext;
			bid_q    <= dres.tag.id;
			bcalls_q <= dres.tag.calls;
			bidx_q   <= dres.tag.idx;
		end
	end

	// result registers: hold until the next non-query transfer or query end
	always_ff @(posedge clk) begin
		if (finish) begin
			if (found_q) begin
				status           <= ST_OK;
				best_id          <= bid_q;
				best_calls       <= bcalls_q;
				best_index       <= OIDX_W'(bidx_q);
				squared_distance <= bd_q[OUTD_W-1:0];
			end else begin
				status           <= ST_NO_MATCH;
				best_id          <= '0;
				best_calls       <= '0;
				best_index       <= '0;
				squared_distance <= '0;
			end
		end else if (accept && !is_query) begin
			best_id          <= '0;
			best_calls       <= '0;
			best_index       <= '0;
			squared_distance <= '0;
			if (is_append && (service_class == CLASS_ANY)) begin
				status <= ST_BAD_CLS;
			end else if (is_append && table_full) begin
				status <= ST_FULL;
			end else begin
				status <= ST_OK;
			end
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ENTRIES))
		else $error("entry count beyond table size");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> (rd_cnt_q < count_q))
		else $error("scan read past stored entries");

	a_pipe_quiet_idle: assert property (@(posedge clk) disable iff (!arst_n)
		dres.valid |-> (state_q != S_IDLE))
		else $error("distance pipeline active outside a query");

	a_query_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("query ended without a result strobe");
`endif

endmodule

@@ rtl/tnps_ram.sv @@
// ----------------------------------------------------------------------------
// tnps_ram: generic single write, single read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tnps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/tnps_dist.sv @@
// ----------------------------------------------------------------------------
// tnps_dist: squared distance pipeline
// Three stages: absolute deltas, squares, sum. Carries the entry tag along.
// ----------------------------------------------------------------------------
module tnps_dist (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	input  tnps_pkg::entry_t                        ent,
	input  logic [tnps_pkg::IDX_W-1:0]              in_idx,
	input  logic signed [tnps_pkg::COORD_W-1:0]     qx,
	input  logic signed [tnps_pkg::COORD_W-1:0]     qy,
	output tnps_pkg::dist_out_t                     dout
);
	import tnps_pkg::*;

	logic                      v_s2, v_s3, v_s4;
	logic [COORD_W-1:0]        ax_s2, ay_s2;
	logic [PROD_W-1:0]         px_s3, py_s3;
	logic [DIST_W-1:0]         sum_s4;
	tag_t                      tag_s2, tag_s3, tag_s4;
	logic signed [COORD_W:0]   dx, dy;
	logic [COORD_W:0]          ndx, ndy;

	always_comb begin
		dx  = {ent.x[COORD_W-1], ent.x} - {qx[COORD_W-1], qx};
		dy  = {ent.y[COORD_W-1], ent.y} - {qy[COORD_W-1], qy};
		ndx = dx[COORD_W] ? (~dx + 1'b1) : dx;
		ndy = dy[COORD_W] ? (~dy + 1'b1) : dy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s2 <= in_valid;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		ax_s2  <= ndx[COORD_W-1:0];
		ay_s2  <= ndy[COORD_W-1:0];
		tag_s2 <= '{idx: in_idx, id: ent.id, cls: ent.cls, calls: ent.calls};
		px_s3  <= ax_s2 * ax_s2;
		py_s3  <= ay_s2 * ay_s2;
		tag_s3 <= tag_s2;
		sum_s4 <= {1'b0, px_s3} + {1'b0, py_s3};
		tag_s4 <= tag_s3;
	end

	assign dout = '{valid: v_s4, busy: v_s2 | v_s3 | v_s4, dist_sq: sum_s4, tag: tag_s4};

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the typed nearest point search core
// Walks a short table of hand-picked commands, then random load/query
// episodes, and compares every result against a cycle-free predictor of
// the service point table or, for some directed rows, a fixed answer.
// ----------------------------------------------------------------------------
module tb_top;

	import tnps_pkg::*;

	localparam logic [1:0]                KIND_UNUSED  = 2'd3;
	localparam logic [CLASS_W-1:0]        CLS_POLICE   = 2'd0;
	localparam logic [CLASS_W-1:0]        CLS_HOSPITAL = 2'd1;
	localparam logic [CLASS_W-1:0]        CLS_FIRE     = 2'd2;
	localparam logic signed [COORD_W-1:0] C_MAX        = 24'h7FFFFF;
	localparam logic signed [COORD_W-1:0] C_MIN        = 24'h800000;

	localparam int N_RANDOM    = 1350;
	localparam int CYCLE_LIMIT = 400000;
	// Covers the longest query, with room left for a stray strobe.
	localparam int DRAIN_WAIT  = MAX_ENTRIES + 16;

	typedef struct packed {
		logic [1:0]                kind;
		logic [ID_W-1:0]           id;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [CLASS_W-1:0]        cls;
		logic [CALLS_W-1:0]        calls;
	} command_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [ID_W-1:0]    id;
		logic [CALLS_W-1:0] calls;
		logic [OIDX_W-1:0]  idx;
		logic [OUTD_W-1:0]  dist_sq;
	} answer_t;

	typedef struct packed {
		command_t cmd;
		logic     typed_ans;
		answer_t  ans;
	} stim_row_t;

	localparam answer_t ANS_OK       = '{status: ST_OK, default: '0};
	localparam answer_t ANS_NO_MATCH = '{status: ST_NO_MATCH, default: '0};
	localparam answer_t ANS_BAD_CLS  = '{status: ST_BAD_CLS, default: '0};

	// Directed commands. Rows with typed_ans set carry an answer that is
	// obvious by inspection; the rest are checked against the predictor.
	localparam int N_DIRECTED = 22;
	localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
		// query on an empty table, typed and any-class
		'{'{KIND_QUERY, 16'd0, 24'sd0, 24'sd0, CLS_POLICE, 16'd0}, 1'b1, ANS_NO_MATCH},
		'{'{KIND_QUERY, 16'd0, 24'sd0, 24'sd0, CLASS_ANY, 16'd0}, 1'b1, ANS_NO_MATCH},
		// append with the any class is refused
		'{'{KIND_APPEND, 16'hFFFF, C_MAX, C_MIN, CLASS_ANY, 16'hFFFF}, 1'b1, ANS_BAD_CLS},
		'{'{KIND_UNUSED, 16'd0, 24'sd0, 24'sd0, CLS_POLICE, 16'd0}, 1'b1, ANS_OK},
		// load: corner points, a tie pair at the origin, one near point
		'{'{KIND_APPEND, 16'hFFFF, C_MAX, C_MAX, CLS_POLICE, 16'hFFFF}, 1'b1, ANS_OK},
		'{'{KIND_APPEND, 16'h0000, C_MIN, C_MIN, CLS_HOSPITAL, 16'h0000}, 1'b1, ANS_OK},
		'{'{KIND_APPEND, 16'd1, 24'sd0, 24'sd0, CLS_FIRE, 16'd100}, 1'b1, ANS_OK},
		'{'{KIND_APPEND, 16'd2, 24'sd0, 24'sd0, CLS_FIRE, 16'd50}, 1'b1, ANS_OK},
		'{'{KIND_APPEND, 16'd3, -24'sd256, 24'sd512, CLS_POLICE, 16'd7}, 1'b1, ANS_OK},
		// widest possible distance
		'{'{KIND_QUERY, 16'd0, C_MAX, C_MAX, CLS_HOSPITAL, 16'd0}, 1'b0, ANS_OK},
		// equal distances: first entry wins
		'{'{KIND_QUERY, 16'd0, 24'sd0, 24'sd0, CLS_FIRE, 16'd0}, 1'b0, ANS_OK},
		// any-class walk: moves only when no farther and fewer calls
		'{'{KIND_QUERY, 16'd0, 24'sd0, 24'sd0, CLASS_ANY, 16'd0}, 1'b0, ANS_OK},
		'{'{KIND_QUERY, 16'd0, -24'sd256, 24'sd512, CLS_POLICE, 16'd0}, 1'b0, ANS_OK},
		'{'{KIND_QUERY, 16'd0, C_MIN, C_MIN, CLASS_ANY, 16'd0}, 1'b0, ANS_OK},
		'{'{KIND_CLEAR, 16'd0, 24'sd0, 24'sd0, CLS_POLICE, 16'd0}, 1'b1, ANS_OK},
		'{'{KIND_QUERY, 16'd0, 24'sd0, 24'sd0, CLS_FIRE, 16'd0}, 1'b1, ANS_NO_MATCH},
		'{'{KIND_APPEND, 16'd10, 24'sd100, 24'sd100, CLS_HOSPITAL, 16'd5}, 1'b1, ANS_OK},
		// class present nowhere in the table
		'{'{KIND_QUERY, 16'd0, 24'sd100, 24'sd100, CLS_POLICE, 16'd0}, 1'b1, ANS_NO_MATCH},
		'{'{KIND_QUERY, 16'd0, C_MIN, C_MAX, CLS_HOSPITAL, 16'd0}, 1'b0, ANS_OK},
		'{'{KIND_UNUSED, 16'hFFFF, C_MAX, C_MAX, CLASS_ANY, 16'hFFFF}, 1'b1, ANS_OK},
		'{'{KIND_CLEAR, 16'hFFFF, C_MIN, C_MAX, CLASS_ANY, 16'hFFFF}, 1'b1, ANS_OK},
		'{'{KIND_QUERY, 16'd0, C_MAX, C_MIN, CLASS_ANY, 16'd0}, 1'b1, ANS_NO_MATCH}
	};

	// Idle percentage per quarter of the random part: none, heavy sender
	// gaps, none (the receiver cannot stall), light gaps.
	localparam int PHASE_IDLE [4] = '{0, 66, 0, 10};

	logic                      clk           = 1'b0;
	logic                      arst_n        = 1'b0;
	logic                      start         = 1'b0;
	logic                      busy;
	logic [1:0]                kind          = KIND_UNUSED;
	logic [ID_W-1:0]           entry_id      = '0;
	logic signed [COORD_W-1:0] pos_x         = '0;
	logic signed [COORD_W-1:0] pos_y         = '0;
	logic [CLASS_W-1:0]        service_class = '0;
	logic [CALLS_W-1:0]        entry_calls   = '0;
	logic                      done;
	logic [1:0]                status;
	logic [ID_W-1:0]           best_id;
	logic [CALLS_W-1:0]        best_calls;
	logic [OIDX_W-1:0]         best_index;
	logic [OUTD_W-1:0]         squared_distance;

	typed_nearest_point_search_core u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.kind             (kind),
		.entry_id         (entry_id),
		.pos_x            (pos_x),
		.pos_y            (pos_y),
		.service_class    (service_class),
		.entry_calls      (entry_calls),
		.done             (done),
		.status           (status),
		.best_id          (best_id),
		.best_calls       (best_calls),
		.best_index       (best_index),
		.squared_distance (squared_distance)
	);

	// Predictor's own copy of the service point table.
	logic [ID_W-1:0]           point_id    [MAX_ENTRIES];
	logic signed [COORD_W-1:0] point_x     [MAX_ENTRIES];
	logic signed [COORD_W-1:0] point_y     [MAX_ENTRIES];
	logic [CLASS_W-1:0]        point_cls   [MAX_ENTRIES];
	logic [CALLS_W-1:0]        point_calls [MAX_ENTRIES];
	int                        stored_count = 0;

	answer_t pending_answers [$];
	answer_t oldest_answer;
	int      idle_pct     = 0;
	int      item_count   = 0;
	int      n_errors     = 0;
	int      n_checked    = 0;
	int      n_append     = 0;
	int      n_full       = 0;
	int      n_bad_cls    = 0;
	int      n_query      = 0;
	int      n_no_match   = 0;
	int      n_clear      = 0;
	int      episode_len;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Exact squared distance, 16 fraction bits, never wider than 49 bits.
	function automatic longint unsigned span_sq(logic signed [COORD_W-1:0] ax,
			logic signed [COORD_W-1:0] ay, logic signed [COORD_W-1:0] bx,
			logic signed [COORD_W-1:0] by);
		logic signed [COORD_W:0] dx;
		logic signed [COORD_W:0] dy;
		longint unsigned         mx;
		longint unsigned         my;
		dx = ax - bx;
		dy = ay - by;
		mx = (dx < 0) ? -dx : dx;
		my = (dy < 0) ? -dy : dy;
		return mx * mx + my * my;
	endfunction

	// Apply one command to the table copy and return the answer it causes.
	function automatic answer_t predict_answer(command_t c);
		answer_t         a;
		logic            found;
		int              best;
		longint unsigned best_d;
		longint unsigned d;
		a      = ANS_OK;
		found  = 1'b0;
		best   = 0;
		best_d = 0;
		case (c.kind)
			KIND_APPEND: begin
				n_append++;
				if (c.cls == CLASS_ANY) begin
					a.status = ST_BAD_CLS;
					n_bad_cls++;
				end else if (stored_count >= MAX_ENTRIES) begin
					a.status = ST_FULL;
					n_full++;
				end else begin
					point_id[stored_count]    = c.id;
					point_x[stored_count]     = c.x;
					point_y[stored_count]     = c.y;
					point_cls[stored_count]   = c.cls;
					point_calls[stored_count] = c.calls;
					stored_count++;
				end
			end
			KIND_CLEAR: begin
				n_clear++;
				stored_count = 0;
			end
			KIND_QUERY: begin
				n_query++;
				if (c.cls == CLASS_ANY) begin
					// start at entry 0; move only if no farther and fewer calls
					if (stored_count > 0) begin
						found  = 1'b1;
						best_d = span_sq(point_x[0], point_y[0], c.x, c.y);
						for (int i = 1; i < stored_count; i++) begin
							d = span_sq(point_x[i], point_y[i], c.x, c.y);
							if (d <= best_d && point_calls[i] < point_calls[best]) begin
								best_d = d;
								best   = i;
							end
						end
					end
				end else begin
					// strict less over matching entries, capped by the range limit
					best_d = LIMIT_SQ;
					for (int i = 0; i < stored_count; i++) begin
						if (point_cls[i] == c.cls) begin
							d = span_sq(point_x[i], point_y[i], c.x, c.y);
							if (d < best_d) begin
								best_d = d;
								best   = i;
								found  = 1'b1;
							end
						end
					end
				end
				if (found) begin
					a.id      = point_id[best];
					a.calls   = point_calls[best];
					a.idx     = best[OIDX_W-1:0];
					a.dist_sq = best_d[OUTD_W-1:0];
				end else begin
					a.status = ST_NO_MATCH;
					n_no_match++;
				end
			end
			default: ;
		endcase
		return a;
	endfunction

	// Coordinates: corners, a crowded patch near the origin, or anything.
	function automatic logic signed [COORD_W-1:0] pick_coord();
		case ($urandom_range(0, 9))
			0:       return C_MAX;
			1:       return C_MIN;
			2, 3, 4: return COORD_W'($urandom_range(0, 4096)) - COORD_W'(2048);
			default: return COORD_W'($urandom);
		endcase
	endfunction

	function automatic command_t make_random(logic [1:0] k);
		command_t c;
		int       j;
		c.kind  = k;
		c.id    = ID_W'($urandom);
		c.calls = $urandom_range(0, 1) ? CALLS_W'($urandom_range(0, 3)) : CALLS_W'($urandom);
		c.x     = pick_coord();
		c.y     = pick_coord();
		if (k == KIND_APPEND)
			c.cls = ($urandom_range(0, 9) == 0) ? CLASS_ANY : CLASS_W'($urandom_range(0, 2));
		else
			c.cls = CLASS_W'($urandom_range(0, 3));
		// Aim some queries right at a stored point to force close calls.
		if (k == KIND_QUERY && stored_count > 0 && $urandom_range(0, 9) < 4) begin
			j   = $urandom_range(0, stored_count - 1);
			c.x = point_x[j] + COORD_W'($urandom_range(0, 8)) - COORD_W'(4);
			c.y = point_y[j] + COORD_W'($urandom_range(0, 8)) - COORD_W'(4);
		end
		return c;
	endfunction

	// Drive one command at the falling edge, hold it until the core takes
	// it, then queue the answer it must produce.
	task automatic send_command(command_t c, logic use_typed, answer_t typed);
		answer_t predicted;
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start         <= 1'b1;
		kind          <= c.kind;
		entry_id      <= c.id;
		pos_x         <= c.x;
		pos_y         <= c.y;
		service_class <= c.cls;
		entry_calls   <= c.calls;
		do @(posedge clk); while (busy);
		predicted = predict_answer(c);
		pending_answers.push_back(use_typed ? typed : predicted);
		if (c.kind != KIND_UNUSED)
			item_count++;
	endtask

	// Check every strobed result against the oldest queued answer.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_answers.size() == 0) begin
				$display("%0t: result with nothing expected (status %0d, id %0d)",
					$time, status, best_id);
				n_errors++;
			end else begin
				oldest_answer = pending_answers.pop_front();
				n_checked++;
				if (status !== oldest_answer.status) begin
					$display("%0t: status mismatch: expected %0d, got %0d",
						$time, oldest_answer.status, status);
					n_errors++;
				end
				if (best_id !== oldest_answer.id) begin
					$display("%0t: best_id mismatch: expected %0d, got %0d",
						$time, oldest_answer.id, best_id);
					n_errors++;
				end
				if (best_calls !== oldest_answer.calls) begin
					$display("%0t: best_calls mismatch: expected %0d, got %0d",
						$time, oldest_answer.calls, best_calls);
					n_errors++;
				end
				if (best_index !== oldest_answer.idx) begin
					$display("%0t: best_index mismatch: expected %0d, got %0d",
						$time, oldest_answer.idx, best_index);
					n_errors++;
				end
				if (squared_distance !== oldest_answer.dist_sq) begin
					$display("%0t: squared_distance mismatch: expected %0d, got %0d",
						$time, oldest_answer.dist_sq, squared_distance);
					n_errors++;
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("%0t: timeout after %0d cycles, %0d answers outstanding",
			$time, CYCLE_LIMIT, pending_answers.size());
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		// Hold reset, then release it on a falling edge.
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < N_DIRECTED; r++)
			send_command(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].typed_ans,
				DIRECTED_ROWS[r].ans);

		// Random episodes: mostly clear, load, then query; some loads run
		// past the table size so full-table refusals show up regularly.
		item_count = 0;
		while (item_count < N_RANDOM) begin
			idle_pct = PHASE_IDLE[(item_count * 4) / N_RANDOM];
			if ($urandom_range(0, 9) < 7)
				send_command(make_random(KIND_CLEAR), 1'b0, ANS_OK);
			episode_len = ($urandom_range(0, 4) == 0) ? $urandom_range(56, 70)
				: $urandom_range(0, 12);
			repeat (episode_len)
				send_command(make_random(($urandom_range(0, 9) == 0) ? KIND_QUERY
					: KIND_APPEND), 1'b0, ANS_OK);
			repeat ($urandom_range(1, 8))
				send_command(make_random(KIND_QUERY), 1'b0, ANS_OK);
			if ($urandom_range(0, 19) == 0)
				send_command(make_random(KIND_UNUSED), 1'b0, ANS_OK);
		end

		// Drop start, wait for every answer, then watch for strays.
		@(negedge clk);
		start <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Covered %0d appends (%0d refused full, %0d bad class), %0d clears,",
			n_append, n_full, n_bad_cls, n_clear);
		$display("%0d queries (%0d with no match); %0d results checked, %0d mismatches",
			n_query, n_no_match, n_checked, n_errors);
		if (n_errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ files.f @@
rtl/tnps_pkg.sv
rtl/tnps_ram.sv
rtl/tnps_dist.sv
rtl/typed_nearest_point_search_core.sv
tb/tb_top.sv
